@@ rtl/stp_pkg.sv @@
// Shared types and constants of the trapezoidal stepper pulse generator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing else.
package stp_pkg;

	// Field and register widths.
	localparam int STEPS_W    = 24;
	localparam int RPM_W      = 10;
	localparam int TARGET_W   = 16;
	localparam int PERIOD_W   = 18;
	localparam int CFG_DATA_W = 16;

	// Defaults of the top-level parameters.
	localparam int COUNT_WIDTH_DEF    = 24;
	localparam int RAMP_STEPS_MAX_DEF = 1600;

	// A short ramp is one third of the move, which fits in this many bits.
	localparam int RAMP_FLOOR_W = 11;

	// Reset values of the configuration registers.
	localparam int RPM_RESET        = 20;
	localparam int MIN_PERIOD_RESET = 800;

	// Pulse timing.
	localparam int HIGH_TICKS    = 3;
	localparam int MIN_PERIOD    = 5;
	localparam int PERIOD_FLOOR  = 10;
	localparam int RPM_DIVIDEND  = 37500;
	localparam int START_SHIFT   = 2;
	localparam int RAMP_SPLIT    = 6000;

	// Division by three of a count below the ramp split, by reciprocal.
	localparam int DIV3_IN_W    = 13;
	localparam int DIV3_RECIP_W = 17;
	localparam int DIV3_RECIP   = 43691;
	localparam int DIV3_SHIFT   = 17;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_UP     = 2'd1,
		PH_CRUISE = 2'd2,
		PH_DOWN   = 2'd3
	} phase_t;

	typedef enum logic {
		CFG_MOTOR_RPM  = 1'b0,
		CFG_MIN_PERIOD = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		DIV_TARGET = 1'b0,
		DIV_PERIOD = 1'b1
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_TDIV,
		ST_MUL,
		ST_DSTART,
		ST_PDIV,
		ST_PUSH
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     item_load;
		logic     eval;
		logic     div_start;
		div_sel_t div_sel;
		logic     tgt_load;
		logic     mul_load;
		logic     period_load;
		logic     out_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_ok;
		logic need_div;
		logic div_done;
	} ctl_sts_t;

endpackage

@@ rtl/stp_channels.sv @@
// Valid/ready channel interfaces: command items, result items, register writes.
// Depends on stp_pkg.
interface stp_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [stp_pkg::STEPS_W-1:0] move_steps;
	logic                        direction;

	modport source(output valid, command, move_steps, direction, input ready);
	modport sink(input valid, command, move_steps, direction, output ready);
endinterface

interface stp_res_if;
	logic valid;
	logic ready;
	logic step_level;
	logic dir_level;
	logic enable_n;
	logic busy_res;
	logic move_done;

	modport source(output valid, step_level, dir_level, enable_n, busy_res, move_done,
		input ready);
	modport sink(input valid, step_level, dir_level, enable_n, busy_res, move_done,
		output ready);
endinterface

interface stp_cfg_if;
	logic                           valid;
	logic                           ready;
	stp_pkg::cfg_reg_t              index;
	logic [stp_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/stepper_trapezoid_pulse_generator.sv @@
// Top level of the trapezoidal stepper pulse generator.
// Depends on stp_pkg, stp_channels, stp_controller, stp_datapath and stp_divider.
//
// Usage:
//   cmd carries items: command 1 starts a move of move_steps microsteps in the
//   given direction, command 0 is one microsecond tick. Every item gives exactly
//   one result item on res with the step, direction and enable levels, busy and
//   the end-of-move flag. cfg writes motor_rpm (index 0) and min_period_us
//   (index 1) and is always ready; the user must see that it is written only
//   while the block is idle, which the block does not enforce. An item is taken
//   only when the previous one has left the datapath. A plain tick is evaluated,
//   then goes to the output register. A tick whose next step lies in a ramp also
//   passes the multiply and period division, and an accepted start the target
//   division, in a divider NUM_W = 18 + ramp width wide (29 at 1600 ramp steps).
//   Reset clears the move to idle and loads 20 rpm and an 800 tick floor.
//   A stalled receiver holds the result in the output register; one more item
//   is taken and worked on meanwhile, and it waits until the register frees.
module stepper_trapezoid_pulse_generator #(
	parameter int COUNT_WIDTH    = stp_pkg::COUNT_WIDTH_DEF,
	parameter int RAMP_STEPS_MAX = stp_pkg::RAMP_STEPS_MAX_DEF
) (
	input logic       clk,
	input logic       arst_n,
	stp_cmd_if.sink   cmd,
	stp_res_if.source res,
	stp_cfg_if.sink   cfg
);

	stp_pkg::ctl_cmd_t ctl_cmd;
	stp_pkg::ctl_sts_t ctl_sts;

	assign cfg.ready = 1'b1;

	stp_controller u_controller (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (ctl_cmd),
		.sts       (ctl_sts)
	);

	stp_datapath #(
		.COUNT_WIDTH    (COUNT_WIDTH),
		.RAMP_STEPS_MAX (RAMP_STEPS_MAX)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl_cmd),
		.sts            (ctl_sts),
		.item_command   (cmd.command),
		.item_steps     (cmd.move_steps),
		.item_direction (cmd.direction),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.step_level     (res.step_level),
		.dir_level      (res.dir_level),
		.enable_n       (res.enable_n),
		.busy_res       (res.busy_res),
		.move_done      (res.move_done)
	);

endmodule

@@ rtl/stp_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing; shared by the datapath for the cruise period and ramp periods.
module stp_divider #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits enter at the bottom as dividend bits leave at the top.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

@@ rtl/stp_controller.sv @@
// Sequencing state machine: takes an item, drives the datapath steps and
// hands the result to the output register. Depends on stp_pkg.
module stp_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output stp_pkg::ctl_cmd_t cmd,
	input  stp_pkg::ctl_sts_t sts
);

	stp_pkg::ctl_state_t state_q;
	stp_pkg::ctl_state_t state_d;
	logic                out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = stp_pkg::DIV_TARGET;
		in_ready    = 1'b0;
		unique case (state_q)
			stp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = stp_pkg::ST_EVAL;
				end
			end
			stp_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.start_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = stp_pkg::DIV_TARGET;
					state_d       = stp_pkg::ST_TDIV;
				end else if (sts.need_div) begin
					state_d = stp_pkg::ST_MUL;
				end else begin
					state_d = stp_pkg::ST_PUSH;
				end
			end
			stp_pkg::ST_TDIV: begin
				if (sts.div_done) begin
					cmd.tgt_load = 1'b1;
					state_d      = stp_pkg::ST_PUSH;
				end
			end
			stp_pkg::ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = stp_pkg::ST_DSTART;
			end
			stp_pkg::ST_DSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = stp_pkg::DIV_PERIOD;
				state_d       = stp_pkg::ST_PDIV;
			end
			stp_pkg::ST_PDIV: begin
				if (sts.div_done) begin
					cmd.period_load = 1'b1;
					state_d         = stp_pkg::ST_PUSH;
				end
			end
			stp_pkg::ST_PUSH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = stp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stp_pkg::ST_IDLE;
			end
		endcase
	end

	// The output register holds its item until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// The divider only finishes while the controller waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == stp_pkg::ST_TDIV || state_q == stp_pkg::ST_PDIV))
		else $error("divider finished outside a divide state");

	// Evaluation always follows an accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stp_pkg::ST_EVAL |-> $past(in_valid && in_ready))
		else $error("evaluation without an accepted item");

	// A waiting result item stays offered until the receiver takes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result item dropped while stalled");
`endif

endmodule

@@ rtl/stp_datapath.sv @@
// Move state, configuration registers, ramp arithmetic and the result registers.
// Depends on stp_pkg and stp_divider.
module stp_datapath #(
	parameter int COUNT_WIDTH    = stp_pkg::COUNT_WIDTH_DEF,
	parameter int RAMP_STEPS_MAX = stp_pkg::RAMP_STEPS_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  stp_pkg::ctl_cmd_t              cmd,
	output stp_pkg::ctl_sts_t              sts,
	input  logic                           item_command,
	input  logic [stp_pkg::STEPS_W-1:0]    item_steps,
	input  logic                           item_direction,
	input  logic                           cfg_we,
	input  stp_pkg::cfg_reg_t              cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           step_level,
	output logic                           dir_level,
	output logic                           enable_n,
	output logic                           busy_res,
	output logic                           move_done
);

	localparam int CW    = COUNT_WIDTH;
	localparam int RCLOG = $clog2(RAMP_STEPS_MAX + 1);
	localparam int RW    = (RCLOG > stp_pkg::RAMP_FLOOR_W) ? RCLOG : stp_pkg::RAMP_FLOOR_W;
	localparam int PW    = stp_pkg::PERIOD_W;
	localparam int TW    = stp_pkg::TARGET_W;
	localparam int NUM_W = PW + RW;
	localparam int D3_W  = stp_pkg::DIV3_IN_W + stp_pkg::DIV3_RECIP_W;

	// Configuration registers.
	logic [stp_pkg::RPM_W-1:0] rpm_q;
	logic [TW-1:0]             min_period_q;

	// Latched item.
	logic                        item_cmd_q;
	logic [stp_pkg::STEPS_W-1:0] item_steps_q;
	logic                        item_dir_q;

	// Move state.
	stp_pkg::phase_t phase_q;
	logic [CW-1:0]   step_q;
	logic [CW-1:0]   cruise_q;
	logic [RW-1:0]   ramp_q;
	logic [TW-1:0]   target_q;
	logic [PW-1:0]   start_q;
	logic [PW-1:0]   period_q;
	logic [PW-1:0]   tick_q;
	logic            dir_q;
	logic [NUM_W-1:0] product_q;

	// Pending result and output register.
	logic res_step_q, res_dir_q, res_busy_q, res_done_q;
	logic out_step_q, out_dir_q, out_busy_q, out_done_q;

	// Tick evaluation.
	logic [CW-1:0]   count;
	logic            running_tick;
	logic [PW-1:0]   tick_inc;
	logic            boundary;
	logic [CW-1:0]   step_set;
	stp_pkg::phase_t ph_set;
	logic            ended;
	logic            start_ok;
	logic            res_busy;

	// Start evaluation.
	logic [NUM_W-1:0] quotient;
	logic             div_done;
	logic [TW-1:0]    div_tgt;
	logic [TW-1:0]    tgt_a;
	logic [TW-1:0]    tgt;
	logic [PW-1:0]    start_p;
	logic [D3_W-1:0]  d3_prod;
	logic [RW-1:0]    ramp_a;
	logic [RW-1:0]    ramp;
	logic [CW-1:0]    cruise;

	// Ramp period arithmetic.
	logic [PW-1:0]    diff;
	logic [NUM_W-1:0] prod_c;
	logic [PW-1:0]    quot_p;
	logic [NUM_W-1:0] div_num;
	logic [RW-1:0]    div_den;

	assign count        = CW'(item_steps_q);
	assign running_tick = !item_cmd_q && (phase_q != stp_pkg::PH_IDLE);
	assign tick_inc     = tick_q + 1'b1;
	assign boundary     = tick_inc >= period_q;
	assign start_ok     = item_cmd_q && (phase_q == stp_pkg::PH_IDLE) && (count != '0)
		&& (rpm_q != '0);

	// Step completion: leave every phase that is finished or empty.
	always_comb begin
		ph_set   = phase_q;
		step_set = step_q + 1'b1;
		ended    = 1'b0;
		if (ph_set == stp_pkg::PH_UP && step_set >= CW'(ramp_q)) begin
			ph_set   = stp_pkg::PH_CRUISE;
			step_set = '0;
		end
		if (ph_set == stp_pkg::PH_CRUISE && step_set >= cruise_q) begin
			ph_set   = stp_pkg::PH_DOWN;
			step_set = '0;
		end
		if (ph_set == stp_pkg::PH_DOWN && step_set >= CW'(ramp_q)) begin
			ph_set   = stp_pkg::PH_IDLE;
			step_set = '0;
			ended    = 1'b1;
		end
	end

	// Busy after this item.
	always_comb begin
		priority if (start_ok) begin
			res_busy = 1'b1;
		end else if (running_tick && boundary) begin
			res_busy = ph_set != stp_pkg::PH_IDLE;
		end else begin
			res_busy = phase_q != stp_pkg::PH_IDLE;
		end
	end

	assign sts.start_ok = start_ok;
	assign sts.need_div = running_tick && boundary && !ended
		&& (ph_set != stp_pkg::PH_CRUISE);
	assign sts.div_done = div_done;

	// Cruise period from the speed, floored by the register and the hard minimum.
	assign div_tgt = quotient[TW-1:0];
	assign tgt_a   = (div_tgt < min_period_q) ? min_period_q : div_tgt;
	assign tgt     = (tgt_a < TW'(stp_pkg::PERIOD_FLOOR)) ? TW'(stp_pkg::PERIOD_FLOOR) : tgt_a;
	assign start_p = PW'(tgt) << stp_pkg::START_SHIFT;

	// Ramp length: a third of a short move, the fixed length otherwise, at most half.
	assign d3_prod = count[stp_pkg::DIV3_IN_W-1:0]
		* stp_pkg::DIV3_RECIP_W'(stp_pkg::DIV3_RECIP);
	assign ramp_a  = (count < CW'(stp_pkg::RAMP_SPLIT))
		? RW'(d3_prod[D3_W-1:stp_pkg::DIV3_SHIFT]) : RW'(RAMP_STEPS_MAX);
	assign ramp    = (CW'({ramp_a, 1'b0}) > count) ? RW'(count >> 1) : ramp_a;
	assign cruise  = count - CW'({ramp, 1'b0});

	// Linear ramp: offset = (start - target) * step / ramp.
	assign diff    = start_q - PW'(target_q);
	assign prod_c  = diff * step_q[RW-1:0];
	assign quot_p  = quotient[PW-1:0];
	assign div_num = (cmd.div_sel == stp_pkg::DIV_TARGET)
		? NUM_W'(stp_pkg::RPM_DIVIDEND) : product_q;
	assign div_den = (cmd.div_sel == stp_pkg::DIV_TARGET) ? RW'(rpm_q) : ramp_q;

	stp_divider #(
		.NUM_W(NUM_W),
		.DEN_W(RW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quotient),
		.done     (div_done)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_q        <= stp_pkg::RPM_W'(stp_pkg::RPM_RESET);
			min_period_q <= TW'(stp_pkg::MIN_PERIOD_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				stp_pkg::CFG_MOTOR_RPM:  rpm_q        <= cfg_data[stp_pkg::RPM_W-1:0];
				stp_pkg::CFG_MIN_PERIOD: min_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item, product and result registers.
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_cmd_q   <= item_command;
			item_steps_q <= item_steps;
			item_dir_q   <= item_direction;
		end
		if (cmd.mul_load) begin
			product_q <= prod_c;
		end
		if (cmd.eval) begin
			res_step_q <= running_tick && (tick_q < PW'(stp_pkg::HIGH_TICKS));
			res_dir_q  <= start_ok ? item_dir_q : dir_q;
			res_busy_q <= res_busy;
			res_done_q <= running_tick && boundary && ended;
		end
		if (cmd.out_load) begin
			out_step_q <= res_step_q;
			out_dir_q  <= res_dir_q;
			out_busy_q <= res_busy_q;
			out_done_q <= res_done_q;
		end
	end

	// Move state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= stp_pkg::PH_IDLE;
			step_q   <= '0;
			cruise_q <= '0;
			ramp_q   <= '0;
			target_q <= '0;
			start_q  <= '0;
			period_q <= '0;
			tick_q   <= '0;
			dir_q    <= 1'b0;
		end else if (cmd.eval && running_tick) begin
			if (boundary) begin
				tick_q  <= '0;
				step_q  <= step_set;
				phase_q <= ph_set;
				if (ended) begin
					period_q <= '0;
				end else if (ph_set == stp_pkg::PH_CRUISE) begin
					period_q <= PW'(target_q);
				end
			end else begin
				tick_q <= tick_inc;
			end
		end else if (cmd.tgt_load) begin
			target_q <= tgt;
			start_q  <= start_p;
			ramp_q   <= ramp;
			cruise_q <= cruise;
			dir_q    <= item_dir_q;
			step_q   <= '0;
			tick_q   <= '0;
			if (ramp == '0) begin
				phase_q  <= stp_pkg::PH_CRUISE;
				period_q <= PW'(tgt);
			end else begin
				phase_q  <= stp_pkg::PH_UP;
				period_q <= start_p;
			end
		end else if (cmd.period_load) begin
			period_q <= (phase_q == stp_pkg::PH_UP) ? start_q - quot_p : PW'(target_q) + quot_p;
		end
	end

	assign step_level = out_step_q;
	assign dir_level  = out_dir_q;
	assign enable_n   = !out_busy_q;
	assign busy_res   = out_busy_q;
	assign move_done  = out_done_q;

`ifndef SYNTHESIS
	// A running move never has a period below the pulse minimum.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != stp_pkg::PH_IDLE |-> period_q >= PW'(stp_pkg::MIN_PERIOD))
		else $error("step period below minimum during a move");

	// The tick counter stays inside the current step.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != stp_pkg::PH_IDLE |-> tick_q < period_q)
		else $error("tick count beyond the step period");

	// Inside a ramp the step index is below the ramp length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == stp_pkg::PH_UP || phase_q == stp_pkg::PH_DOWN) |-> step_q < CW'(ramp_q))
		else $error("ramp step index out of range");
`endif

endmodule
